### hdl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg - shared types and constants for the sliding window median block
// Sample type, default window size and the control word that travels with
// each compared pair.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int unsigned DATA_W     = 16;
	localparam int unsigned WINDOW_DEF = 8;

	typedef logic signed [DATA_W-1:0] sample_t;

	// control for one compared pair in flight
	typedef struct packed {
		logic vld;   // pair is live
		logic last;  // last pair of the current candidate's sweep
	} pair_ctl_t;

endpackage
`default_nettype wire

### hdl/swm_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_window - sample window memory
// One write port and two registered read ports. Per-entry valid bits make
// never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module swm_window #(
	parameter int unsigned WINDOW = swm_pkg::WINDOW_DEF,
	parameter int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      wr_en,
	input  wire [IDX_W-1:0]          wr_addr,
	input  wire swm_pkg::sample_t    wr_data,
	input  wire [IDX_W-1:0]          rd_a_addr,
	input  wire [IDX_W-1:0]          rd_b_addr,
	output swm_pkg::sample_t         rd_a_data,
	output swm_pkg::sample_t         rd_b_data
);
	import swm_pkg::*;

	sample_t            mem [WINDOW];
	logic [WINDOW-1:0]  vld_q;
	sample_t            rd_a_q;
	sample_t            rd_b_q;
	logic               rd_a_vld_q;
	logic               rd_b_vld_q;

	// storage write and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	// valid bits: cleared by reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_a_vld_q <= vld_q[rd_a_addr];
			rd_b_vld_q <= vld_q[rd_b_addr];
		end
	end

	// unwritten entries read as zero
	assign rd_a_data = rd_a_vld_q ? rd_a_q : '0;
	assign rd_b_data = rd_b_vld_q ? rd_b_q : '0;

endmodule
`default_nettype wire

### hdl/swm_rank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_rank - shared compare and rank counter
// Compares the candidate against one window entry per cycle and counts the
// entries that sort ahead of it (smaller, or equal with a lower slot). At
// the end of a sweep it flags the candidate whose rank is the middle one.
// ----------------------------------------------------------------------------
module swm_rank #(
	parameter int unsigned WINDOW = swm_pkg::WINDOW_DEF,
	parameter int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      clr,
	input  wire swm_pkg::pair_ctl_t  ctl,
	input  wire swm_pkg::sample_t    cand,
	input  wire swm_pkg::sample_t    other,
	input  wire [IDX_W-1:0]          cand_idx,
	input  wire [IDX_W-1:0]          other_idx,
	output logic                     hit
);
	import swm_pkg::*;

	localparam int unsigned CNT_W = $clog2(WINDOW + 1);
	localparam int unsigned MID   = WINDOW / 2;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nxt;
	logic             ahead;
	logic             live;

	// stable order: smaller value, or equal value from a lower slot
	assign ahead   = (other < cand) || ((other == cand) && (other_idx < cand_idx));
	assign cnt_nxt = cnt_q + CNT_W'(ahead);
	assign live    = en && ctl.vld;
	assign hit     = live && ctl.last && (cnt_nxt == CNT_W'(MID));

	// rank accumulator, restarted per candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (live) begin
			if (ctl.last) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_nxt;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/sliding_window_median_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_top - running median over a window of samples
// Each sample overwrites the oldest window entry; the result is the entry
// at sorted position WINDOW/2 (upper middle for even sizes).
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid/in_stall    sample (16 b, signed)
//  output    out_valid/out_stall  median (16 b, signed)
//
//  The median beat is offered when the sweep of c, the slot of the median
//  entry, ends, or later if the output register is still full. The next
//  input beat is taken only after that result has gone into the output
//  register. One comparator sweeps the candidate/entry pairs through the
//  two-port window memory until the median candidate is found. Input
//  stalls while a sample is worked on or while a finished result waits
//  behind a full output register. Reset zeroes the window through
//  per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
	parameter int unsigned WINDOW = swm_pkg::WINDOW_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire swm_pkg::sample_t  sample,
	output logic                   out_valid,
	input  wire                    out_stall,
	output swm_pkg::sample_t       median
);
	import swm_pkg::*;

	localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] cand_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] cand_s1;
	logic [IDX_W-1:0] scan_s1;
	pair_ctl_t        ctl_s1;
	sample_t          res_q;
	sample_t          median_q;
	logic             out_valid_q;

	sample_t          cand_data;
	sample_t          scan_data;
	logic             accept;
	logic             run;
	logic             hit;
	logic             out_free;
	logic             load_out;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign run       = (state_q == ST_RUN);
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = out_free && ((run && hit) || (state_q == ST_HOLD));
	assign out_valid = out_valid_q;
	assign median    = median_q;

	swm_window #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_addr   (slot_q),
		.wr_data   (sample),
		.rd_a_addr (cand_q),
		.rd_b_addr (scan_q),
		.rd_a_data (cand_data),
		.rd_b_data (scan_data)
	);

	swm_rank #(
		.WINDOW (WINDOW),
		.IDX_W  (IDX_W)
	) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (run),
		.clr       (accept),
		.ctl       (ctl_s1),
		.cand      (cand_data),
		.other     (scan_data),
		.cand_idx  (cand_s1),
		.other_idx (scan_s1),
		.hit       (hit)
	);

	// pair tags aligned with the registered memory reads
	always_ff @(posedge clk) begin
		cand_s1 <= cand_q;
		scan_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= run;
			ctl_s1.last <= (scan_q == LAST_IDX);
		end
	end

	// sequencer: ring write, pair sweep, result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			cand_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q  <= (slot_q == LAST_IDX) ? '0 : slot_q + IDX_W'(1);
						cand_q  <= '0;
						scan_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (scan_q == LAST_IDX) begin
						scan_q <= '0;
						cand_q <= (cand_q == LAST_IDX) ? '0 : cand_q + IDX_W'(1);
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
					if (hit) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (run && hit) begin
			res_q <= cand_data;
			if (out_free) begin
				median_q <= cand_data;
			end
		end else if ((state_q == ST_HOLD) && out_free) begin
			median_q <= res_q;
		end
	end

endmodule
`default_nettype wire
